// ===== src/khm_pkg.sv =====
// khm_pkg: shared constants, types and helpers for the k-th largest heap block
// no dependencies; imported by the interfaces and every module of the block

package khm_pkg;

    // heap sizing
    localparam int HEAP_DEPTH = 16;
    localparam int IDX_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KID_W      = ((IDX_W + 2) > (CNT_W + 1)) ? (IDX_W + 2) : (CNT_W + 1);

    // field widths
    localparam int VAL_W = 32;
    localparam int K_W   = 5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VAL_W-1:0] SIGN_BIT = {1'b1, {(VAL_W-1){1'b0}}};

    // heap operation chosen by the front
    typedef enum logic {
        OP_FILL    = 1'b0,
        OP_REPLACE = 1'b1
    } khm_kind_t;

    // one classified item handed from front to back
    typedef struct packed {
        khm_kind_t         kind;
        logic [IDX_W-1:0]  pos;
        logic [VAL_W-1:0]  key;
        logic              last;
        logic              full;
    } khm_op_t;

    // signed value to key whose unsigned order is the signed order
    function automatic logic [VAL_W-1:0] to_key(input logic [VAL_W-1:0] v);
        return v ^ SIGN_BIT;
    endfunction

endpackage

// ===== src/khm_if.sv =====
// khm_if: valid/ready channel interfaces for sample input, result output and rank config
// depends on khm_pkg

interface khm_in_if;
    import khm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] sample_value;
    logic                    last_item;
    modport source (output valid, sample_value, last_item, input ready);
    modport sink   (input valid, sample_value, last_item, output ready);
endinterface

interface khm_out_if;
    import khm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] kth_value;
    logic                    result_valid;
    modport source (output valid, kth_value, result_valid, input ready);
    modport sink   (input valid, kth_value, result_valid, output ready);
endinterface

interface khm_cfg_if;
    import khm_pkg::*;
    logic           valid;
    logic           ready;
    logic [K_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== src/khm_front.sv =====
// khm_front: takes sample transfers and rank writes, tracks the fill count, classifies items
// depends on khm_pkg and khm_if

module khm_front (
    input  logic            clk,
    input  logic            rst_n,
    khm_in_if.sink          sample_in,
    khm_cfg_if.sink         cfg,
    output logic            op_valid,
    input  logic            op_ready,
    output khm_pkg::khm_op_t op,
    output logic [khm_pkg::CNT_W-1:0] k_use
);
    import khm_pkg::*;

    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_after;
    logic             fill;
    logic             take;

    assign cfg.ready       = 1'b1;
    assign sample_in.ready = op_ready;
    assign op_valid        = sample_in.valid;
    assign take            = sample_in.valid && op_ready;
    assign k_use           = k_reg;

    // rank clamp: zero acts as one, above depth acts as depth
    always_comb
    begin
        if (int'(cfg.data) > HEAP_DEPTH)
            k_next = CNT_W'(HEAP_DEPTH);
        else if (cfg.data == '0)
            k_next = CNT_W'(1);
        else
            k_next = CNT_W'(cfg.data);
    end

    // classify the item against the fill count
    always_comb
    begin
        fill        = count_reg < k_reg;
        count_after = fill ? count_reg + CNT_W'(1) : count_reg;
        op.kind     = fill ? OP_FILL : OP_REPLACE;
        op.pos      = IDX_W'(count_reg);
        op.key      = to_key(sample_in.sample_value);
        op.last     = sample_in.last_item;
        op.full     = count_after >= k_reg;
        count_next  = sample_in.last_item ? '0 : count_after;
    end

    // rank and fill count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= CNT_W'(1);
            count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            k_reg     <= k_next;
            count_reg <= '0;
        end
        else if (take)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/khm_queue.sv =====
// khm_queue: short fifo of classified operations between front and back
// depends on khm_pkg

module khm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  khm_pkg::khm_op_t push_op,
    output logic             pop_valid,
    input  logic             pop_ready,
    output khm_pkg::khm_op_t pop_op,
    output logic [khm_pkg::QC_W-1:0] level
);
    import khm_pkg::*;

    khm_op_t         slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] count_reg;
    logic            push;
    logic            pop;

    assign push_ready = count_reg < QC_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign level      = count_reg;

    // pointer wrap helper
    function automatic logic [QP_W-1:0] bump(input logic [QP_W-1:0] p);
        if (int'(p) == QUEUE_DEPTH - 1)
            return '0;
        return p + QP_W'(1);
    endfunction

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    // pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + QC_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QC_W'(1);
        end
    end

endmodule

// ===== src/khm_back.sv =====
// khm_back: heap memory and sift sequencer, plus the result output register
// depends on khm_pkg and khm_if

module khm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  khm_pkg::khm_op_t op,
    input  logic [khm_pkg::CNT_W-1:0] k_use,
    khm_out_if.source        result_out
);
    import khm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_UP_STEP   = 6'b000010,
        S_UP_CMP    = 6'b000100,
        S_DOWN_STEP = 6'b001000,
        S_DOWN_CMP  = 6'b010000,
        S_EMIT      = 6'b100000
    } khm_state_t;

    khm_state_t       state_reg;
    khm_state_t       state_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [VAL_W-1:0] key_reg;
    logic [VAL_W-1:0] key_next;
    logic             last_reg;
    logic             last_next;
    logic             full_reg;
    logic             full_next;

    logic [VAL_W-1:0] heap_mem [HEAP_DEPTH];
    logic [VAL_W-1:0] rd_a_reg;
    logic [VAL_W-1:0] rd_b_reg;
    logic [VAL_W-1:0] root_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_flag_reg;
    logic             out_load;

    logic [IDX_W-1:0] parent;
    logic [KID_W-1:0] kid;
    logic [KID_W-1:0] kid2;
    logic [KID_W-1:0] k_wide;
    logic             pick_right;
    logic [VAL_W-1:0] child_val;
    logic [IDX_W-1:0] child_idx;

    // tree index arithmetic
    always_comb
    begin
        parent     = IDX_W'((pos_reg - IDX_W'(1)) >> 1);
        kid        = (KID_W'(pos_reg) << 1) + KID_W'(1);
        kid2       = kid + KID_W'(1);
        k_wide     = KID_W'(k_use);
        pick_right = (kid2 < k_wide) && (rd_a_reg > rd_b_reg);
        child_val  = pick_right ? rd_b_reg : rd_a_reg;
        child_idx  = pick_right ? kid2[IDX_W-1:0] : kid[IDX_W-1:0];
    end

    // sift sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        last_next  = last_reg;
        full_next  = full_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = key_reg;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        op_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    key_next  = op.key;
                    last_next = op.last;
                    full_next = op.full;
                    if (op.kind == OP_FILL)
                    begin
                        pos_next   = op.pos;
                        state_next = S_UP_STEP;
                    end
                    else if (op.key > root_reg)
                    begin
                        pos_next   = '0;
                        state_next = S_DOWN_STEP;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_UP_STEP:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr_a  = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_a_reg > key_reg)
                begin
                    wr_data    = rd_a_reg;
                    pos_next   = parent;
                    state_next = S_UP_STEP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DOWN_STEP:
            begin
                if (kid >= k_wide)
                begin
                    wr_en      = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr_a  = kid[IDX_W-1:0];
                    rd_addr_b  = kid2[IDX_W-1:0];
                    state_next = S_DOWN_CMP;
                end
            end
            S_DOWN_CMP:
            begin
                wr_en = 1'b1;
                if (key_reg > child_val)
                begin
                    wr_data    = child_val;
                    pos_next   = child_idx;
                    state_next = S_DOWN_STEP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || result_out.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // heap memory with registered reads and a copy of the root
    always_ff @(posedge clk)
    begin
        if (wr_en)
            heap_mem[wr_addr] <= wr_data;
        if (wr_en && wr_addr == '0)
            root_reg <= wr_data;
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        last_reg <= last_next;
        full_reg <= full_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= full_reg ? to_key(root_reg) : '0;
            out_flag_reg  <= full_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.kth_value    = out_value_reg;
    assign result_out.result_valid = out_flag_reg;

endmodule

// ===== src/kth_largest_min_heap.sv =====
// kth_largest_min_heap: top level joining front, operation queue and heap back end
// depends on khm_pkg, khm_if, khm_front, khm_queue and khm_back
//
// Usage: samples arrive on sample_in, one signed value per transfer, with
// last_item marking the end of a run. A result transfer leaves on result_out
// only for the last item of a run: kth_value is the k-th largest value of the
// run and result_valid is 1, or both are 0 when fewer than k values came.
// The rank k is written on cfg (0 acts as 1, above 16 acts as 16); a write
// also starts a new run. Write it only while the block is idle.
// Timing: the front takes a sample in the cycle it is offered while the
// two-entry queue has room. The back end processes one item at a time from
// the queue, using a 16-entry heap memory with two registered read ports:
// each heap level takes a read state, then a compare and write state, with
// a sift depth of up to log2 of k levels. When its sift ends, the back end
// enters the emit state, which loads a run's result into the output register.
// If the receiver stalls, the result holds, the back end waits on the next
// result, and the queue keeps taking samples until it is full.
// Reset: rank 1, fill count zero, queue and output empty; the heap memory
// is not cleared, since only entries written in the current run are used.

module kth_largest_min_heap (
    input  logic       clk,
    input  logic       rst_n,
    khm_in_if.sink     sample_in,
    khm_cfg_if.sink    cfg,
    khm_out_if.source  result_out
);
    import khm_pkg::*;

    logic             f_valid;
    logic             f_ready;
    khm_op_t          f_op;
    logic             q_valid;
    logic             q_ready;
    khm_op_t          q_op;
    logic [CNT_W-1:0] k_use;
    logic [QC_W-1:0]  q_level;

    // classification
    khm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .cfg       (cfg),
        .op_valid  (f_valid),
        .op_ready  (f_ready),
        .op        (f_op),
        .k_use     (k_use)
    );

    // decoupling queue
    khm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_op    (f_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_op     (q_op),
        .level      (q_level)
    );

    // heap engine
    khm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (q_valid),
        .op_ready   (q_ready),
        .op         (q_op),
        .k_use      (k_use),
        .result_out (result_out)
    );

    // a fill never lands at or beyond the rank in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && f_ready && f_op.kind == OP_FILL) |-> (CNT_W'(f_op.pos) < k_use))
        else $error("fill position beyond rank");

    // a short run reports zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.result_valid) |-> (result_out.kth_value == '0))
        else $error("short run result not zero");

    // a full queue blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == QC_W'(QUEUE_DEPTH)) |-> !sample_in.ready)
        else $error("queue full but input ready");

endmodule
